### sv/wtaq_pkg.sv
// ----------------------------------------------------------------------------
// wtaq_pkg
// Shared types and constants for the wait-time admission queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wtaq_pkg;

	// Request store geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths
	localparam int TAG_W    = 16;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int TARGET_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_ARRIVAL  = 2'd0,
		OP_DEQUEUE  = 2'd1,
		OP_COMPLETE = 2'd2,
		OP_UNUSED   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_OVER_LIMIT = 3'd1,
		ST_STALE     = 3'd2,
		ST_FULL      = 3'd3,
		ST_GRANTED   = 3'd4,
		ST_DROPPED   = 3'd5,
		ST_EMPTY     = 3'd6,
		ST_COMPLETED = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_STATIC   = 2'd1,
		MODE_PRIORITY = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_LOW_LIMIT = 2'd2,
		REG_TARGET    = 2'd3
	} cfg_reg_t;

	// Classified command handed from front to back
	typedef struct packed {
		opcode_t               op;
		logic [TAG_W-1:0]      tag;
		logic [TIME_W-1:0]     now;
		logic                  limited;
		logic [COUNT_W-1:0]    limit;
		logic [TARGET_W-1:0]   target;
	} cmd_t;

endpackage

`default_nettype wire

### sv/wtaq_front.sv
// ----------------------------------------------------------------------------
// wtaq_front
// Configuration registers; accepts commands and classifies them into beats
// for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wtaq_front
	import wtaq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	input  wire logic                  queue_full,
	input  wire logic [1:0]            opcode,
	input  wire logic [1:0]            tier,
	input  wire logic [TAG_W-1:0]      request_tag,
	input  wire logic [TIME_W-1:0]     now_time,
	output logic                       push,
	output cmd_t                       cmd
);

	mode_t               mode_q;
	logic [COUNT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  low_limit_q;
	logic [TARGET_W-1:0] target_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STATIC;
			limit_q     <= COUNT_W'(12);
			low_limit_q <= COUNT_W'(10);
			target_q    <= TARGET_W'(50);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:      mode_q      <= mode_t'(cfg_data[1:0]);
				REG_LIMIT:     limit_q     <= cfg_data[COUNT_W-1:0];
				REG_LOW_LIMIT: low_limit_q <= cfg_data[COUNT_W-1:0];
				REG_TARGET:    target_q    <= cfg_data[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	// Unused opcode is swallowed: no beat, no result
	assign push = start && !queue_full && (opcode_t'(opcode) != OP_UNUSED);

	always_comb begin
		cmd.op      = opcode_t'(opcode);
		cmd.tag     = request_tag;
		cmd.now     = now_time;
		cmd.limited = (mode_q == MODE_STATIC) || (mode_q == MODE_PRIORITY);
		cmd.limit   = ((mode_q == MODE_PRIORITY) && (tier != 2'd0)) ? low_limit_q : limit_q;
		cmd.target  = target_q;
	end

endmodule

`default_nettype wire

### sv/wtaq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// wtaq_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module wtaq_cmd_fifo
	import wtaq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wr_data,
	input  wire logic pop,
	output cmd_t      rd_data,
	output logic      full,
	output logic      empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full    = (fill_q == 2'd2);
	assign empty   = (fill_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/wtaq_back.sv
// ----------------------------------------------------------------------------
// wtaq_back
// Executes commands against the request store one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module wtaq_back
	import wtaq_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_empty,
	input  cmd_t              cmd_in,
	output logic              pop,
	output logic              result_valid,
	output logic [2:0]        status,
	output logic [TAG_W-1:0]  out_tag,
	output logic [TIME_W-1:0] waited,
	output logic [COUNT_W-1:0] in_flight,
	output logic [CNT_W-1:0]  queue_length,
	output logic              last
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [PTR_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]  inflight_q;

	logic [TIME_W-1:0]   stamp_mem [QUEUE_DEPTH];
	logic [TAG_W-1:0]    tag_mem   [QUEUE_DEPTH];
	logic [TIME_W-1:0]   head_stamp_q;
	logic [TAG_W-1:0]    head_tag_q;

	logic                valid_q;
	status_t             status_q;
	logic [TAG_W-1:0]    tag_q;
	logic [TIME_W-1:0]   waited_q;
	logic                last_q;

	// next-state / result signals
	logic                emit, done, wr_en, stale, has_entry;
	logic [TIME_W-1:0]   age;
	logic [COUNT_W-1:0]  inc, dec;
	logic [PTR_W-1:0]    head_n, tail_n;
	logic [CNT_W-1:0]    count_n;
	logic [COUNT_W-1:0]  inflight_n;
	status_t             r_status;
	logic [TAG_W-1:0]    r_tag;
	logic [TIME_W-1:0]   r_waited;
	logic                r_last;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pop = (state_q == S_IDLE) && !cmd_empty;

	always_comb begin
		has_entry  = (count_q != '0);
		age        = has_entry ? (cmd_q.now - head_stamp_q) : '0;
		stale      = has_entry && (age > {{(TIME_W-TARGET_W){1'b0}}, cmd_q.target});
		inc        = (inflight_q == {COUNT_W{1'b1}}) ? inflight_q : inflight_q + 1'b1;
		dec        = (inflight_q == '0) ? inflight_q : inflight_q - 1'b1;
		emit       = 1'b0;
		done       = 1'b0;
		wr_en      = 1'b0;
		head_n     = head_q;
		tail_n     = tail_q;
		count_n    = count_q;
		inflight_n = inflight_q;
		r_status   = ST_ACCEPTED;
		r_tag      = cmd_q.tag;
		r_waited   = age;
		r_last     = 1'b1;
		if (state_q == S_RUN) begin
			emit = 1'b1;
			done = 1'b1;
			unique case (cmd_q.op)
				OP_ARRIVAL: begin
					if (cmd_q.limited && (inflight_q >= cmd_q.limit)) begin
						r_status = ST_OVER_LIMIT;
					end else if (cmd_q.limited && stale) begin
						r_status = ST_STALE;
					end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
						r_status = ST_FULL;
					end else begin
						wr_en      = 1'b1;
						tail_n     = next_ptr(tail_q);
						count_n    = count_q + 1'b1;
						inflight_n = inc;
					end
				end
				OP_DEQUEUE: begin
					if (cmd_q.limited && stale) begin
						// expired head: drop and keep walking
						r_status   = ST_DROPPED;
						r_tag      = head_tag_q;
						r_last     = 1'b0;
						done       = 1'b0;
						head_n     = next_ptr(head_q);
						count_n    = count_q - 1'b1;
						inflight_n = dec;
					end else if (has_entry) begin
						r_status = ST_GRANTED;
						r_tag    = head_tag_q;
						head_n   = next_ptr(head_q);
						count_n  = count_q - 1'b1;
					end else begin
						r_status = ST_EMPTY;
						r_tag    = '0;
						r_waited = '0;
					end
				end
				OP_COMPLETE: begin
					r_status   = ST_COMPLETED;
					r_waited   = '0;
					inflight_n = dec;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[tail_q] <= cmd_q.now;
			tag_mem[tail_q]   <= cmd_q.tag;
		end
		// head entry held in registers; a write into the next head slot passes through
		if (wr_en && (tail_q == head_n)) begin
			head_stamp_q <= cmd_q.now;
			head_tag_q   <= cmd_q.tag;
		end else begin
			head_stamp_q <= stamp_mem[head_n];
			head_tag_q   <= tag_mem[head_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			inflight_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			head_q     <= head_n;
			tail_q     <= tail_n;
			count_q    <= count_n;
			inflight_q <= inflight_n;
			valid_q    <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd_in;
		end
		if (emit) begin
			status_q <= r_status;
			tag_q    <= r_tag;
			waited_q <= r_waited;
			last_q   <= r_last;
		end
	end

	assign result_valid = valid_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign waited       = waited_q;
	assign in_flight    = inflight_q;
	assign queue_length = count_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above store depth");

	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status_q == ST_DROPPED)) |-> !last_q)
		else $error("drop beat flagged last");

	a_strobe_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_RUN))
		else $error("result beat without a command in progress");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> !pop)
		else $error("command popped while one is in progress");
`endif

endmodule

`default_nettype wire

### sv/wait_time_admission_queue_core.sv
// ----------------------------------------------------------------------------
// wait_time_admission_queue_core
// Wait-time admission control over a timestamped request queue.
// ----------------------------------------------------------------------------
// An accepted command goes through the command queue and the command register
//   before its result beat is registered; each beat lasts one cycle. Commands
//   run one at a time (idle, then run state); drop beats come one per cycle.
// The receiver cannot stall; busy rises only while the command queue is full.
// Reset (arst_n low, asynchronous) empties queues and counts and loads the
//   register defaults; no clearing pass is needed.
`default_nettype none

module wait_time_admission_queue_core
	import wtaq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            opcode,
	input  wire logic [1:0]            tier,
	input  wire logic [TAG_W-1:0]      request_tag,
	input  wire logic [TIME_W-1:0]     now_time,
	// result side
	output logic                       result_valid,
	output logic [2:0]                 status,
	output logic [TAG_W-1:0]           out_tag,
	output logic [TIME_W-1:0]          waited,
	output logic [COUNT_W-1:0]         in_flight,
	output logic [CNT_W-1:0]           queue_length,
	output logic                       last
);

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// busy only reflects the command queue, so the front keeps taking beats
	// while the back end walks expired entries
	assign busy = q_full;

	// Front: register file plus opcode/tier classification
	wtaq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.queue_full  (q_full),
		.opcode      (opcode),
		.tier        (tier),
		.request_tag (request_tag),
		.now_time    (now_time),
		.push        (push),
		.cmd         (front_cmd)
	);

	// Decoupling queue
	wtaq_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_cmd),
		.pop     (pop),
		.rd_data (back_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Back: request store, in-flight count, result beats
	wtaq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (q_empty),
		.cmd_in       (back_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.status       (status),
		.out_tag      (out_tag),
		.waited       (waited),
		.in_flight    (in_flight),
		.queue_length (queue_length),
		.last         (last)
	);

endmodule

`default_nettype wire

### tb/wtaq_checker.sv
// ----------------------------------------------------------------------------
// wtaq_checker
// Watches the command, config and result channels of the admission queue,
// keeps its own copy of the queue and counters, predicts every result beat
// and compares it field by field in arrival order.
// ----------------------------------------------------------------------------

module wtaq_checker
	import wtaq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	input  logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [1:0]            tier,
	input  logic [TAG_W-1:0]      request_tag,
	input  logic [TIME_W-1:0]     now_time,
	input  logic                  result_valid,
	input  logic [2:0]            status,
	input  logic [TAG_W-1:0]      out_tag,
	input  logic [TIME_W-1:0]     waited,
	input  logic [COUNT_W-1:0]    in_flight,
	input  logic [CNT_W-1:0]      queue_length,
	input  logic                  last,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		status_t              status;
		logic [TAG_W-1:0]     tag;
		logic [TIME_W-1:0]    waited;
		logic [COUNT_W-1:0]   in_flight;
		logic [CNT_W-1:0]     queue_length;
		logic                 last;
	} result_beat_t;

	// predicted queue state
	logic [TIME_W-1:0]  stamps [QUEUE_DEPTH];
	logic [TAG_W-1:0]   tags [QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_slot = '0;
	logic [PTR_W-1:0]   tail_slot = '0;
	logic [CNT_W-1:0]   held = '0;
	logic [COUNT_W-1:0] in_flight_q = '0;

	// register copy
	mode_t                mode_q = MODE_STATIC;
	logic [COUNT_W-1:0]   limit_q = 8'd12;
	logic [COUNT_W-1:0]   low_limit_q = 8'd10;
	logic [TARGET_W-1:0]  target_q = 16'd50;

	result_beat_t due_results[$];
	int           errors = 0;

	assign fail_count = errors;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TIME_W-1:0] head_age(input logic [TIME_W-1:0] now);
		return (held == '0) ? '0 : now - stamps[head_slot];
	endfunction

	function automatic void release_slot();
		if (in_flight_q != '0)
			in_flight_q = in_flight_q - 1'b1;
	endfunction

	// counts in the beat are the ones after the event
	function automatic void post(input status_t st, input logic [TAG_W-1:0] tg,
		input logic [TIME_W-1:0] w, input logic lst);
		result_beat_t b;
		b.status       = st;
		b.tag          = tg;
		b.waited       = w;
		b.in_flight    = in_flight_q;
		b.queue_length = held;
		b.last         = lst;
		due_results.insert(due_results.size(), b);
	endfunction

	function automatic void admit_command(input opcode_t op, input logic [1:0] tr,
		input logic [TAG_W-1:0] tg, input logic [TIME_W-1:0] now);
		logic               limited;
		logic [COUNT_W-1:0] ceiling;
		logic [TIME_W-1:0]  age;
		logic [TAG_W-1:0]   head_tag;
		status_t            st;
		limited = (mode_q == MODE_STATIC) || (mode_q == MODE_PRIORITY);
		case (op)
			OP_ARRIVAL: begin
				age = head_age(now);
				st  = ST_ACCEPTED;
				if (limited) begin
					ceiling = (mode_q == MODE_PRIORITY && tr != 2'd0) ? low_limit_q : limit_q;
					if (in_flight_q >= ceiling)
						st = ST_OVER_LIMIT;
					else if (held != '0 && age > TIME_W'(target_q))
						st = ST_STALE;
				end
				// full is only looked at once the limit tests passed
				if (st == ST_ACCEPTED && held == CNT_W'(QUEUE_DEPTH))
					st = ST_FULL;
				if (st == ST_ACCEPTED) begin
					stamps[tail_slot] = now;
					tags[tail_slot]   = tg;
					tail_slot         = advance(tail_slot);
					held              = held + 1'b1;
					if (in_flight_q != '1)
						in_flight_q = in_flight_q + 1'b1;
				end
				post(st, tg, age, 1'b1);
			end
			OP_DEQUEUE: begin
				if (limited) begin
					while (held != '0 && head_age(now) > TIME_W'(target_q)) begin
						age       = head_age(now);
						head_tag  = tags[head_slot];
						head_slot = advance(head_slot);
						held      = held - 1'b1;
						release_slot();
						post(ST_DROPPED, head_tag, age, 1'b0);
					end
				end
				if (held != '0) begin
					age       = head_age(now);
					head_tag  = tags[head_slot];
					head_slot = advance(head_slot);
					held      = held - 1'b1;
					// granted entry stays in flight until its completion
					post(ST_GRANTED, head_tag, age, 1'b1);
				end else begin
					post(ST_EMPTY, '0, '0, 1'b1);
				end
			end
			OP_COMPLETE: begin
				release_slot();
				post(ST_COMPLETED, tg, '0, 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_beat_t got;
		result_beat_t want;
		if (!arst_n) begin
			head_slot   = '0;
			tail_slot   = '0;
			held        = '0;
			in_flight_q = '0;
			mode_q      = MODE_STATIC;
			limit_q     = 8'd12;
			low_limit_q = 8'd10;
			target_q    = 16'd50;
			due_results.delete();
			pending <= 0;
		end else begin
			if (result_valid === 1'b1) begin
				got.status       = status_t'(status);
				got.tag          = out_tag;
				got.waited       = waited;
				got.in_flight    = in_flight;
				got.queue_length = queue_length;
				got.last         = last;
				if (due_results.size() == 0) begin
					if (errors < PRINT_CAP)
						$display("%0t: unexpected result beat: status %0d tag %h waited %h",
							$time, status, out_tag, waited);
					errors++;
				end else begin
					want = due_results[0];
					due_results.delete(0);
					if (got !== want) begin
						if (errors < PRINT_CAP)
							$display({"%0t: result mismatch: expected status %0d tag %h ",
								"waited %h in_flight %0d queue %0d last %0b; got status %0d ",
								"tag %h waited %h in_flight %0d queue %0d last %0b"},
								$time, want.status, want.tag, want.waited, want.in_flight,
								want.queue_length, want.last, got.status, got.tag,
								got.waited, got.in_flight, got.queue_length, got.last);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:      mode_q      = mode_t'(cfg_data[1:0]);
					REG_LIMIT:     limit_q     = cfg_data[COUNT_W-1:0];
					REG_LOW_LIMIT: low_limit_q = cfg_data[COUNT_W-1:0];
					default:       target_q    = cfg_data[TARGET_W-1:0];
				endcase
			end
			if (start && !busy)
				admit_command(opcode_t'(opcode), tier, request_tag, now_time);
			pending <= due_results.size();
		end
	end

endmodule

### tb/wait_time_admission_queue_core_test.sv
// ----------------------------------------------------------------------------
// wait_time_admission_queue_core_test
// Drives arrivals, dequeues and completions into the admission queue under
// several register settings, with a checker alongside that predicts and
// compares every result beat; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------

module wait_time_admission_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wtaq_pkg::*;

	// Longest dequeue is 16 drops plus its final beat; settle past that so an
	// ignored command is also out of the pipe.
	localparam int SETTLE_CYCLES    = 24;
	// Quiet cycles tolerated before the run is called hung.
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_ITEMS      = 43;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            opcode = '0;
	logic [1:0]            tier = '0;
	logic [TAG_W-1:0]      request_tag = '0;
	logic [TIME_W-1:0]     now_time = '0;
	logic                  result_valid;
	logic [2:0]            status;
	logic [TAG_W-1:0]      out_tag;
	logic [TIME_W-1:0]     waited;
	logic [COUNT_W-1:0]    in_flight;
	logic [CNT_W-1:0]      queue_length;
	logic                  last;

	int fail_count;
	int pending;
	int quiet_cycles = 0;

	// sender burst shaping
	int burst_left = 0;
	bit gaps_on = 1'b1;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	wait_time_admission_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.tier         (tier),
		.request_tag  (request_tag),
		.now_time     (now_time),
		.result_valid (result_valid),
		.status       (status),
		.out_tag      (out_tag),
		.waited       (waited),
		.in_flight    (in_flight),
		.queue_length (queue_length),
		.last         (last)
	);

	wtaq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.tier         (tier),
		.request_tag  (request_tag),
		.now_time     (now_time),
		.result_valid (result_valid),
		.status       (status),
		.out_tag      (out_tag),
		.waited       (waited),
		.in_flight    (in_flight),
		.queue_length (queue_length),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// One command beat. Bursts of random length; between bursts start drops
	// for a random gap, possibly zero. Back-to-back beats keep start high, so
	// start gets only one nonblocking write per edge.
	task automatic issue(input opcode_t op, input logic [1:0] tr,
		input logic [TAG_W-1:0] tg, input logic [TIME_W-1:0] stamp);
		int gap;
		if (burst_left == 0) begin
			gap        = gaps_on ? $urandom_range(0, 6) : 0;
			burst_left = $urandom_range(1, 10);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start       <= 1'b1;
		opcode      <= op;
		tier        <= tr;
		request_tag <= tg;
		now_time    <= stamp;
		// accepted on the edge where busy was low
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// One config beat; valid is left high so writes can run back to back.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	// Writes all four registers. Bits above a register's width are noise the
	// block must drop.
	task automatic set_config(input mode_t md, input logic [COUNT_W-1:0] lim,
		input logic [COUNT_W-1:0] low_lim, input logic [TARGET_W-1:0] tgt);
		write_reg(REG_MODE, {14'($urandom), md});
		write_reg(REG_LIMIT, {8'($urandom), lim});
		write_reg(REG_LOW_LIMIT, {8'($urandom), low_lim});
		write_reg(REG_TARGET, tgt);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every predicted beat has come back, then let the pipe settle
	// (a trailing ignored command leaves nothing to wait for).
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hang detector: counts edges where no beat moves on any channel.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int                  i;
		int                  ph;
		int                  n;
		int                  pick;
		int                  arr_pct;
		int                  step_max;
		opcode_t             op;
		mode_t               md;
		logic [COUNT_W-1:0]  lim;
		logic [COUNT_W-1:0]  low_lim;
		logic [TARGET_W-1:0] tgt;
		logic [TIME_W-1:0]   clock_now;
		logic [TIME_W-1:0]   stamp;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: reset defaults (static, limit 12, low 10, target 50) ----
		// completion with nothing in flight: count stays at zero
		issue(OP_COMPLETE, 2'd0, 16'hFFFF, 32'd0);
		// dequeue on an empty queue
		issue(OP_DEQUEUE, 2'd3, 16'h1234, 32'd5);
		// opcode 3 is ignored: no beat, no state change
		issue(OP_UNUSED, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
		issue(OP_ARRIVAL, 2'd0, 16'h0000, 32'hFFFF_FFF0);
		// timestamp wraps; head age equals the target exactly, still tolerated
		issue(OP_ARRIVAL, 2'd1, 16'hFFFF, 32'h0000_0022);
		// one past the target: stale queue refusal
		issue(OP_ARRIVAL, 2'd2, 16'hA5A5, 32'h0000_0023);
		// head expired -> dropped, second entry granted
		issue(OP_DEQUEUE, 2'd0, 16'h0000, 32'h0000_0024);
		issue(OP_COMPLETE, 2'd0, 16'h5A5A, 32'h0000_0025);
		drain();

		// mode none: seventeenth arrival finds the store full
		set_config(MODE_NONE, 8'd12, 8'd10, 16'd50);
		for (i = 0; i < QUEUE_DEPTH + 1; i++)
			issue(OP_ARRIVAL, i[1:0], TAG_W'($urandom), 32'd1000 + i);
		drain();

		// Full store under static mode with target 0: stale wins over full.
		// Then one dequeue walks out all 16 entries plus the empty beat.
		set_config(MODE_STATIC, 8'd255, 8'd10, 16'd0);
		issue(OP_ARRIVAL, 2'd0, TAG_W'($urandom), 32'd2000);
		issue(OP_DEQUEUE, 2'd0, TAG_W'($urandom), 32'd2001);
		drain();

		// priority tiers: low tiers hit their own ceiling first
		set_config(MODE_PRIORITY, 8'd3, 8'd1, 16'd65535);
		issue(OP_ARRIVAL, 2'd1, TAG_W'($urandom), 32'd3000);
		issue(OP_ARRIVAL, 2'd2, TAG_W'($urandom), 32'd3001);
		issue(OP_ARRIVAL, 2'd3, TAG_W'($urandom), 32'd3002);
		issue(OP_ARRIVAL, 2'd0, TAG_W'($urandom), 32'd3003);
		drain();

		// zero ceiling refuses every limited arrival of that class
		set_config(MODE_PRIORITY, 8'd3, 8'd0, 16'd65535);
		issue(OP_ARRIVAL, 2'd1, TAG_W'($urandom), 32'd3004);
		issue(OP_ARRIVAL, 2'd0, TAG_W'($urandom), 32'd3005);
		issue(OP_ARRIVAL, 2'd0, TAG_W'($urandom), 32'd3006);
		drain();

		// ---- random phases, one register setting each ----
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					md = MODE_NONE; lim = 8'($urandom_range(1, 20));
					low_lim = 8'($urandom_range(1, 20)); tgt = 16'($urandom_range(0, 300));
				end
				1: begin
					md = MODE_STATIC; lim = 8'd1; low_lim = 8'd255; tgt = 16'd0;
				end
				2: begin
					md = MODE_PRIORITY; lim = 8'd255; low_lim = 8'd1; tgt = 16'hFFFF;
				end
				3: begin
					md = MODE_UNUSED; lim = 8'd0; low_lim = 8'd0;
					tgt = 16'($urandom_range(20, 400));
				end
				4: begin
					md = MODE_NONE; lim = 8'($urandom); low_lim = 8'($urandom);
					tgt = 16'($urandom);
				end
				5: begin
					// roomy ceiling and target so the store fills in a limited mode
					md = MODE_STATIC; lim = 8'd255; low_lim = 8'($urandom); tgt = 16'hFFFF;
				end
				6: begin
					md = MODE_PRIORITY; lim = 8'($urandom_range(4, 16));
					low_lim = 8'($urandom_range(1, 4)); tgt = 16'($urandom_range(20, 400));
				end
				default: begin
					md = MODE_STATIC; lim = 8'($urandom_range(4, 16)); low_lim = 8'd0;
					tgt = 16'($urandom_range(20, 400));
				end
			endcase
			set_config(md, lim, low_lim, tgt);

			// Time steps scale with the target so waits straddle it; random
			// start point makes the wrap show up somewhere.
			clock_now  = $urandom;
			step_max   = tgt / 8 + 3;
			arr_pct    = (ph == 5) ? 60 : $urandom_range(35, 50);
			gaps_on    = (ph % 3 != 1);
			burst_left = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// an occasional jump past the target forces stale heads and drops in limited modes
				if ($urandom_range(0, 19) == 0)
					clock_now = clock_now + tgt + $urandom_range(1, 64);
				else
					clock_now = clock_now + $urandom_range(0, step_max);
				// rare out-of-order timestamp as noise
				stamp = ($urandom_range(0, 31) == 0) ? TIME_W'($urandom) : clock_now;
				pick  = $urandom_range(0, 99);
				if (pick < arr_pct)
					op = OP_ARRIVAL;
				else if (pick < arr_pct + 30)
					op = OP_DEQUEUE;
				else if (pick < 96)
					op = OP_COMPLETE;
				else
					op = OP_UNUSED;
				issue(op, 2'($urandom_range(0, 3)), TAG_W'($urandom), stamp);
			end
			drain();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### wait_time_admission_queue_core.f
sv/wtaq_pkg.sv
sv/wtaq_front.sv
sv/wtaq_cmd_fifo.sv
sv/wtaq_back.sv
sv/wait_time_admission_queue_core.sv
tb/wtaq_checker.sv
tb/wait_time_admission_queue_core_test.sv
